// File: rtl/core/platform_interrupt_controller_core_defines.svh
// Assertion macros shared by the interrupt controller core modules.
`ifndef PLATFORM_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PIC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/pic_pkg.sv
// Types and constants of the interrupt controller core.
`default_nettype none

package pic_pkg;

	typedef enum logic [1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_RAISE = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [21:0] offset;
		logic [3:0]  access_width;
		logic [31:0] write_data;
		logic [5:0]  source_id;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        access_ok;
		logic        irq_request;
	} rsp_t;

	localparam logic [3:0]  ACCESS_BYTES = 4'd4;
	localparam logic [21:0] PEND_BASE    = 22'h001000;
	localparam logic [21:0] ENAB_BASE    = 22'h002000;
	localparam logic [21:0] THRESH_ADDR  = 22'h201000;
	localparam logic [21:0] CLAIM_ADDR   = 22'h201004;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EXEC  = 7'b0000010,
		ST_PRIO  = 7'b0000100,
		ST_SCAN  = 7'b0001000,
		ST_FLUSH = 7'b0010000,
		ST_FIN   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	// Sequencer to scan unit: one candidate per cycle.
	typedef struct packed {
		logic       clear;
		logic       eval;
		logic       cand;
		logic [2:0] pri;
		logic [5:0] idx;
	} scan_ctl_t;

	typedef struct packed {
		logic       found;
		logic       multi;
		logic [5:0] best_id;
	} scan_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/pic_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module pic_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/pic_scan.sv
// Shared compare unit: tracks the best claimable source over a serial scan.
`default_nettype none

`include "platform_interrupt_controller_core_defines.svh"

module pic_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pic_pkg::scan_ctl_t ctl,
	input  wire logic [2:0]        threshold,
	output pic_pkg::scan_sts_t     sts
);

	logic       found_q;
	logic       multi_q;
	logic [5:0] best_id_q;
	logic [2:0] lead_pri_q;
	logic       claimable;

	assign claimable = ctl.cand && (ctl.pri > threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			multi_q    <= 1'b0;
			best_id_q  <= '0;
			lead_pri_q <= '0;
		end else if (ctl.clear) begin
			found_q    <= 1'b0;
			multi_q    <= 1'b0;
			best_id_q  <= '0;
			lead_pri_q <= '0;
		end else if (ctl.eval && claimable) begin
			// a second claimable source keeps irq up after a claim
			multi_q <= multi_q | found_q;
			found_q <= 1'b1;
			// strict compare: lowest id wins a tie
			if (ctl.pri > lead_pri_q) begin
				lead_pri_q <= ctl.pri;
				best_id_q  <= ctl.idx;
			end
		end
	end

	assign sts = '{found: found_q, multi: multi_q, best_id: best_id_q};

	`PIC_ASSERT(a_multi_needs_found, multi_q, found_q, "second candidate without a first")
	`PIC_ASSERT(a_found_has_id, 1'b1, found_q == (best_id_q != 6'd0), "found flag and id disagree")
	`PIC_ASSERT(a_best_above_thr, found_q, lead_pri_q > threshold, "best not above threshold")

endmodule

`default_nettype wire

// File: rtl/core/platform_interrupt_controller_core.sv
// Single-context interrupt controller core: sequencer, register state, priority RAM.
// Response: registered in DONE after EXEC, PRIO (on a priority read only), SCAN, FLUSH and FIN.
// A request is taken only when the last response has been posted; the serial source scan does
// one priority RAM read and one compare per cycle; a stalled response holds off the next.
// Reset: arst_n clears priorities (valid bits), pending, enable, threshold and control.
`default_nettype none

`include "platform_interrupt_controller_core_defines.svh"

module platform_interrupt_controller_core #(
	parameter int NUM_SOURCES = 63
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire pic_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output pic_pkg::rsp_t      rsp
);

	localparam int          PrioDepth = NUM_SOURCES + 1;
	localparam int          PrioAw    = $clog2(PrioDepth);
	localparam logic [5:0]  LastId    = 6'(NUM_SOURCES);
	localparam logic [21:0] PrioEnd   = 22'(4 * PrioDepth);

	pic_pkg::state_t state_q;
	pic_pkg::req_t   req_q;
	logic [63:0]     pending_q;
	logic [63:0]     enable_q;
	logic [2:0]      thresh_q;
	logic [PrioDepth-1:0] prio_vld_q;
	logic [31:0]     rd_q;
	logic            ok_q;
	logic            irq_q;
	logic            claim_q;
	logic [5:0]      scan_idx_q;
	logic            vld_s1;
	logic            cand_s1;
	logic            pv_s1;
	logic [5:0]      idx_s1;
	logic            rsp_valid_q;
	pic_pkg::rsp_t   rsp_q;

	logic            is_bus, width_ok, do_read, do_write;
	logic            in_prio, in_pend, in_enab, hit_thr, hit_claim, src_ok;
	logic [5:0]      prio_id;
	logic [31:0]     rd_exec;
	logic            rsp_load;

	logic                ram_we;
	logic [PrioAw-1:0]   ram_raddr;
	logic [2:0]          ram_rdata;

	pic_pkg::scan_ctl_t scan_ctl;
	pic_pkg::scan_sts_t scan_sts;

	always_comb begin
		is_bus    = (req_q.func == pic_pkg::FUNC_READ) || (req_q.func == pic_pkg::FUNC_WRITE);
		width_ok  = req_q.access_width == pic_pkg::ACCESS_BYTES;
		do_read   = (req_q.func == pic_pkg::FUNC_READ) && width_ok;
		do_write  = (req_q.func == pic_pkg::FUNC_WRITE) && width_ok;
		in_prio   = req_q.offset < PrioEnd;
		in_pend   = req_q.offset[21:3] == pic_pkg::PEND_BASE[21:3];
		in_enab   = req_q.offset[21:3] == pic_pkg::ENAB_BASE[21:3];
		hit_thr   = req_q.offset == pic_pkg::THRESH_ADDR;
		hit_claim = req_q.offset == pic_pkg::CLAIM_ADDR;
		prio_id   = req_q.offset[7:2];
		src_ok    = (req_q.source_id != 6'd0) && (req_q.source_id <= LastId);

		rd_exec = '0;
		if (do_read) begin
			if (in_pend) begin
				rd_exec = req_q.offset[2] ? pending_q[63:32] : pending_q[31:0];
			end else if (in_enab) begin
				rd_exec = req_q.offset[2] ? enable_q[63:32] : enable_q[31:0];
			end else if (hit_thr) begin
				rd_exec = {29'd0, thresh_q};
			end
		end
	end

	// priority RAM: written and read at the decoded id in EXEC, scanned afterwards
	assign ram_we    = (state_q == pic_pkg::ST_EXEC) && do_write && in_prio && (prio_id != 6'd0);
	assign ram_raddr = (state_q == pic_pkg::ST_EXEC) ? prio_id[PrioAw-1:0]
	                                                 : scan_idx_q[PrioAw-1:0];

	pic_ram #(
		.WIDTH (3),
		.DEPTH (PrioDepth)
	) u_prio_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (prio_id[PrioAw-1:0]),
		.wdata (req_q.write_data[2:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign scan_ctl = '{
		clear: state_q == pic_pkg::ST_EXEC,
		eval:  vld_s1,
		cand:  cand_s1,
		pri:   pv_s1 ? ram_rdata : 3'd0,
		idx:   idx_s1
	};

	pic_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.threshold (thresh_q),
		.sts       (scan_sts)
	);

	assign req_stall = state_q != pic_pkg::ST_IDLE;
	assign rsp_load  = (state_q == pic_pkg::ST_DONE) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pic_pkg::ST_IDLE;
			pending_q  <= '0;
			enable_q   <= '0;
			thresh_q   <= '0;
			prio_vld_q <= '0;
			scan_idx_q <= '0;
			vld_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			vld_s1 <= state_q == pic_pkg::ST_SCAN;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				pic_pkg::ST_IDLE: begin
					if (req_valid) begin
						state_q <= pic_pkg::ST_EXEC;
					end
				end
				pic_pkg::ST_EXEC: begin
					scan_idx_q <= 6'd1;
					if (ram_we) begin
						prio_vld_q[prio_id[PrioAw-1:0]] <= 1'b1;
					end
					if (do_write && in_enab) begin
						if (req_q.offset[2]) begin
							enable_q[63:32] <= req_q.write_data;
						end else begin
							enable_q[31:0] <= {req_q.write_data[31:1], 1'b0};
						end
					end
					if (do_write && hit_thr) begin
						thresh_q <= req_q.write_data[2:0];
					end
					if (!is_bus && src_ok) begin
						pending_q[req_q.source_id] <= req_q.func == pic_pkg::FUNC_RAISE;
					end
					if (do_read && in_prio) begin
						state_q <= pic_pkg::ST_PRIO;
					end else begin
						state_q <= pic_pkg::ST_SCAN;
					end
				end
				pic_pkg::ST_PRIO: begin
					state_q <= pic_pkg::ST_SCAN;
				end
				pic_pkg::ST_SCAN: begin
					if (scan_idx_q == LastId) begin
						state_q <= pic_pkg::ST_FLUSH;
					end else begin
						scan_idx_q <= scan_idx_q + 6'd1;
					end
				end
				pic_pkg::ST_FLUSH: begin
					state_q <= pic_pkg::ST_FIN;
				end
				pic_pkg::ST_FIN: begin
					if (claim_q && scan_sts.found) begin
						pending_q[scan_sts.best_id] <= 1'b0;
					end
					state_q <= pic_pkg::ST_DONE;
				end
				pic_pkg::ST_DONE: begin
					if (rsp_load) begin
						state_q <= pic_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pic_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == pic_pkg::ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == pic_pkg::ST_EXEC) begin
			rd_q    <= rd_exec;
			ok_q    <= !is_bus || width_ok;
			claim_q <= do_read && hit_claim;
		end
		if (state_q == pic_pkg::ST_PRIO) begin
			rd_q <= {29'd0, prio_vld_q[prio_id[PrioAw-1:0]] ? ram_rdata : 3'd0};
		end
		if (state_q == pic_pkg::ST_SCAN) begin
			idx_s1  <= scan_idx_q;
			cand_s1 <= pending_q[scan_idx_q] & enable_q[scan_idx_q];
			pv_s1   <= prio_vld_q[scan_idx_q[PrioAw-1:0]];
		end
		if (state_q == pic_pkg::ST_FIN) begin
			// after a claim, irq stays up only if another source was claimable
			irq_q <= claim_q ? scan_sts.multi : scan_sts.found;
			if (claim_q) begin
				rd_q <= {26'd0, scan_sts.best_id};
			end
		end
		if (rsp_load) begin
			rsp_q <= '{read_data: rd_q, access_ok: ok_q, irq_request: irq_q};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PIC_ASSERT_NEXT(a_accept_to_exec, req_valid && !req_stall, state_q == pic_pkg::ST_EXEC, "request not executed")
	`PIC_ASSERT(a_enable_bit0, 1'b1, !enable_q[0], "source 0 enabled")
	`PIC_ASSERT(a_pending_bit0, 1'b1, !pending_q[0], "source 0 pending")
	`PIC_ASSERT_NEXT(a_load_shows_rsp, rsp_load, rsp_valid && (state_q == pic_pkg::ST_IDLE), "response not posted")

endmodule

`default_nettype wire
